// File: design/gpio_port_register_block_core_defines.svh
// Assertion macros shared by the GPIO port register block RTL.
`ifndef GPIO_PORT_REGISTER_BLOCK_CORE_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPIORB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gpiorb assertion failed");

// Next-cycle implication, checked outside reset.
`define GPIORB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gpiorb assertion failed");

`endif

// File: design/gpiorb_pkg.sv
// Shared constants, codes and types of the GPIO port register block.
`default_nettype none
package gpiorb_pkg;

    localparam int PORT_BLOCKS = 16;
    localparam int BLK_W = (PORT_BLOCKS > 1) ? $clog2(PORT_BLOCKS) : 1;
    // Wide enough to hold any block number from the bus offset and the constant itself.
    localparam int IDX_W = 7;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DRIVE = 2'd2;

    localparam logic [3:0] GRP_FSEL = 4'h0;
    localparam logic [3:0] GRP_DIR  = 4'h2;
    localparam logic [3:0] GRP_IN   = 4'h3;
    localparam logic [3:0] GRP_OUT  = 4'h4;
    localparam logic [3:0] GRP_EXT  = 4'h6;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_BAD  = 2'd3;

    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd1;

    localparam logic [31:0] HALF_HI = 32'hffff0000;

    typedef struct packed {
        logic [31:0] fsel;
        logic [31:0] ext;
        logic [31:0] dir;
        logic [31:0] din;
        logic [31:0] dout;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [3:0]  drive_block;
        logic [3:0]  drive_bit;
        logic [1:0]  drive_level;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        port_changed;
        logic [3:0]  changed_block;
        logic [15:0] output_mask;
        logic [15:0] output_levels;
        logic        irq_request_valid;
        logic [7:0]  irq_request_port;
        logic        irq_request_level;
    } t_rsp;

endpackage
`default_nettype wire

// File: design/gpiorb_ifs.sv
// Request and response channel interfaces of the GPIO port register block.
`default_nettype none
interface gpiorb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [11:0] offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [3:0]  drive_block;
    logic [3:0]  drive_bit;
    logic [1:0]  drive_level;

    modport source (
        output valid, op, offset, access_size, write_data, drive_block, drive_bit,
               drive_level,
        input  ready
    );
    modport sink (
        input  valid, op, offset, access_size, write_data, drive_block, drive_bit,
               drive_level,
        output ready
    );
endinterface

interface gpiorb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        port_changed;
    logic [3:0]  changed_block;
    logic [15:0] output_mask;
    logic [15:0] output_levels;
    logic        irq_request_valid;
    logic [7:0]  irq_request_port;
    logic        irq_request_level;

    modport source (
        output valid, read_data, port_changed, changed_block, output_mask, output_levels,
               irq_request_valid, irq_request_port, irq_request_level,
        input  ready
    );
    modport sink (
        input  valid, read_data, port_changed, changed_block, output_mask, output_levels,
               irq_request_valid, irq_request_port, irq_request_level,
        output ready
    );
endinterface
`default_nettype wire

// File: design/gpiorb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gpiorb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [WIDTH-1:0]   i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [WIDTH-1:0]   o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/gpiorb_upd.sv
// Read-modify-write logic: turns one request and the block's row into a new row and a result.
`default_nettype none
module gpiorb_upd (
    input  wire gpiorb_pkg::t_req i_req,
    input  wire logic             i_in_range,
    input  wire gpiorb_pkg::t_row i_row,
    output gpiorb_pkg::t_row      o_row,
    output logic                  o_we,
    output gpiorb_pkg::t_rsp      o_rsp
);
    logic [3:0]  grp;
    logic [4:0]  shift;
    logic [31:0] rword;
    logic [31:0] wmask;
    logic [31:0] wval;
    logic [15:0] omask;
    logic [15:0] din_lo_n;
    logic [15:0] fsel_lo;
    logic [15:0] dir_lo;
    logic        gpio_out;

    assign grp      = i_req.offset[11:8];
    assign shift    = {i_req.offset[1:0], 3'b000};
    assign fsel_lo  = i_row.fsel[15:0];
    assign dir_lo   = i_row.dir[15:0];
    assign gpio_out = !fsel_lo[i_req.drive_bit] && dir_lo[i_req.drive_bit];

    // Register selected for a bus read; unmapped groups read as zero.
    always_comb begin
        case (grp)
            gpiorb_pkg::GRP_FSEL: rword = i_row.fsel;
            gpiorb_pkg::GRP_DIR:  rword = i_row.dir;
            gpiorb_pkg::GRP_IN:   rword = i_row.din;
            gpiorb_pkg::GRP_OUT:  rword = i_row.dout;
            gpiorb_pkg::GRP_EXT:  rword = i_row.ext;
            default:              rword = '0;
        endcase
    end

    // Lane mask and aligned data of a bus write.
    always_comb begin
        case (i_req.access_size)
            gpiorb_pkg::SZ_BYTE: begin
                wmask = 32'h0000_00ff << shift;
                wval  = {24'h0, i_req.write_data[7:0]} << shift;
            end
            gpiorb_pkg::SZ_HALF: begin
                wmask = i_req.offset[1] ? gpiorb_pkg::HALF_HI : ~gpiorb_pkg::HALF_HI;
                wval  = i_req.offset[1] ? {i_req.write_data[15:0], 16'h0}
                                        : {16'h0, i_req.write_data[15:0]};
            end
            default: begin
                wmask = '1;
                wval  = i_req.write_data;
            end
        endcase
    end

    always_comb begin
        o_row    = i_row;
        o_we     = 1'b0;
        o_rsp    = '0;
        omask    = '0;
        din_lo_n = i_row.din[15:0];
        din_lo_n[i_req.drive_bit] = i_req.drive_level[0];
        case (i_req.op)
            gpiorb_pkg::OP_READ: begin
                if (i_in_range) begin
                    case (i_req.access_size)
                        gpiorb_pkg::SZ_BYTE: o_rsp.read_data = (rword >> shift) & 32'h0000_00ff;
                        gpiorb_pkg::SZ_HALF: o_rsp.read_data = i_req.offset[1]
                                                ? {16'h0, rword[31:16]}
                                                : {16'h0, rword[15:0]};
                        gpiorb_pkg::SZ_WORD: o_rsp.read_data = rword;
                        default:             o_rsp.read_data = '0;
                    endcase
                end
            end
            gpiorb_pkg::OP_WRITE: begin
                if (i_in_range && (i_req.access_size != gpiorb_pkg::SZ_BAD)) begin
                    o_we = 1'b1;
                    case (grp)
                        gpiorb_pkg::GRP_FSEL: o_row.fsel = (i_row.fsel & ~wmask) | (wval & wmask);
                        gpiorb_pkg::GRP_DIR:  o_row.dir  = (i_row.dir & ~wmask) | (wval & wmask);
                        gpiorb_pkg::GRP_OUT:  o_row.dout = (i_row.dout & ~wmask) | (wval & wmask);
                        gpiorb_pkg::GRP_EXT:  o_row.ext  = (i_row.ext & ~wmask) | (wval & wmask);
                        default:              o_we = 1'b0;
                    endcase
                    if ((o_row.dout != i_row.dout) || (o_row.dir != i_row.dir)) begin
                        o_row.din = (i_row.din & ~o_row.dir) | (o_row.dout & o_row.dir);
                        omask = o_row.dir[15:0] & ~o_row.fsel[15:0];
                        o_rsp.port_changed  = 1'b1;
                        o_rsp.changed_block = i_req.offset[5:2];
                        o_rsp.output_mask   = omask;
                        o_rsp.output_levels = o_row.dout[15:0] & omask;
                    end
                end
            end
            gpiorb_pkg::OP_DRIVE: begin
                if (i_in_range && !gpio_out &&
                    (i_req.drive_level inside {gpiorb_pkg::LVL_LOW, gpiorb_pkg::LVL_HIGH})) begin
                    o_we      = 1'b1;
                    o_row.din = {i_row.din[31:16], din_lo_n};
                    o_rsp.irq_request_valid = 1'b1;
                    o_rsp.irq_request_port  = {i_req.drive_block, i_req.drive_bit};
                    o_rsp.irq_request_level = i_req.drive_level[0];
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: design/gpio_port_register_block_core.sv
// Top level of the GPIO port register block: sequencer, register memory and result register.
`default_nettype none
`include "gpio_port_register_block_core_defines.svh"
// The block holds the function-select, extended-function, direction, input-data and
// output-data registers of every port block as one row of a single register memory,
// one row per block. Each transaction on the request channel (bus read, bus write or
// external pin drive) passes through the idle and execute states: in idle the addressed
// row is read from the memory, whose read data is registered, and in execute the row is
// modified, written back and the result is loaded into the output register. A new
// request is taken as soon as the sequencer is back in its idle state, even while the
// previous result still waits on the response channel; if that result is still not
// taken when the next one is ready, the block holds in the execute cycle. Rows that
// were never written read as zero through per-row valid bits, so no clearing pass is
// needed after reset. Every request produces exactly one response transaction.
module gpio_port_register_block_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gpiorb_in_if.sink   i_req,
    gpiorb_out_if.source o_rsp
);
    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                             r_state;
    logic                               r_out_valid;
    gpiorb_pkg::t_rsp                   r_rsp;
    logic [gpiorb_pkg::PORT_BLOCKS-1:0] r_row_valid;

    gpiorb_pkg::t_req                   r_req;
    logic [gpiorb_pkg::BLK_W-1:0]       r_addr;
    logic                               r_in_range;

    logic                               accept;
    logic [gpiorb_pkg::IDX_W-1:0]       idx;
    logic [gpiorb_pkg::BLK_W-1:0]       n_addr;
    logic                               n_in_range;
    logic [gpiorb_pkg::ROW_W-1:0]       ram_rdata;
    gpiorb_pkg::t_row                   row_cur;
    gpiorb_pkg::t_row                   row_new;
    logic                               upd_we;
    gpiorb_pkg::t_rsp                   upd_rsp;
    logic                               out_free;
    logic                               ram_we;

    // No request is taken while the block is held in reset.
    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign accept      = i_req.valid && i_req.ready;

    // Pin drives address their block directly, bus accesses through offset bits 7..2.
    assign idx = (i_req.op == gpiorb_pkg::OP_DRIVE)
                 ? {3'b000, i_req.drive_block}
                 : {1'b0, i_req.offset[7:2]};
    assign n_in_range = (idx < gpiorb_pkg::IDX_W'(gpiorb_pkg::PORT_BLOCKS));
    assign n_addr     = idx[gpiorb_pkg::BLK_W-1:0];

    // Request payload is held for the execute cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op          <= i_req.op;
            r_req.offset      <= i_req.offset;
            r_req.access_size <= i_req.access_size;
            r_req.write_data  <= i_req.write_data;
            r_req.drive_block <= i_req.drive_block;
            r_req.drive_bit   <= i_req.drive_bit;
            r_req.drive_level <= i_req.drive_level;
            r_addr            <= n_addr;
            r_in_range        <= n_in_range;
        end
    end

    gpiorb_ram #(
        .WIDTH (gpiorb_pkg::ROW_W),
        .DEPTH (gpiorb_pkg::PORT_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (row_new),
        .i_re    (accept),
        .i_raddr (n_addr),
        .o_rdata (ram_rdata)
    );

    // A row that was never written holds its reset value, all zero.
    assign row_cur = r_row_valid[r_addr] ? gpiorb_pkg::t_row'(ram_rdata) : '0;

    gpiorb_upd u_upd (
        .i_req      (r_req),
        .i_in_range (r_in_range),
        .i_row      (row_cur),
        .o_row      (row_new),
        .o_we       (upd_we),
        .o_rsp      (upd_rsp)
    );

    // The execute cycle completes only when the output register can take its result.
    assign out_free = !r_out_valid || o_rsp.ready;
    assign ram_we   = (r_state == S_EXEC) && out_free && upd_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rsp       <= '0;
            r_row_valid <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_rsp       <= upd_rsp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (upd_we) begin
                            r_row_valid[r_addr] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.read_data         = r_rsp.read_data;
    assign o_rsp.port_changed      = r_rsp.port_changed;
    assign o_rsp.changed_block     = r_rsp.changed_block;
    assign o_rsp.output_mask       = r_rsp.output_mask;
    assign o_rsp.output_levels     = r_rsp.output_levels;
    assign o_rsp.irq_request_valid = r_rsp.irq_request_valid;
    assign o_rsp.irq_request_port  = r_rsp.irq_request_port;
    assign o_rsp.irq_request_level = r_rsp.irq_request_level;

    // A write report and an interrupt request never come from the same transaction.
    `GPIORB_ASSERT_NOW(a_report_excl, i_clk, i_rst_n, o_rsp.valid, !(o_rsp.port_changed && o_rsp.irq_request_valid))
    // Writes and drives return no read data.
    `GPIORB_ASSERT_NOW(a_rd_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.port_changed || o_rsp.irq_request_valid), o_rsp.read_data == '0)
    // Every accepted request moves the sequencer into its execute cycle.
    `GPIORB_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == S_EXEC)
    // The memory is written back only in an execute cycle that completes.
    `GPIORB_ASSERT_NOW(a_wr_exec, i_clk, i_rst_n, ram_we, (r_state == S_EXEC) && out_free)
    // A completed execute cycle always leaves a result in the output register.
    `GPIORB_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, (r_state == S_EXEC) && out_free, o_rsp.valid)
endmodule
`default_nettype wire
